// ===== hw/rtl/bct_pkg.sv =====
package bct_pkg;

  localparam int COORD_W = 9;
  localparam int SCAN_W  = 10;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    HEAD_NORTH,
    HEAD_EAST,
    HEAD_SOUTH,
    HEAD_WEST
  } heading_t;

  typedef enum logic [1:0] {
    PH_LOADING,
    PH_SCANNING,
    PH_WALKING,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BUILD,
    ST_FLUSH,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_WALK_UPD,
    ST_EMIT_DONE
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic load_px;
    logic scan_init;
    logic build_step;
    logic scan_rd;
    logic scan_wrap;
    logic scan_next;
    logic start;
    logic walk_rd;
    logic walk_upd;
    logic emit_done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic build_empty;
    logic build_last;
    logic row_ok;
    logic col_ok;
    logic mask_bit;
    logic walk_close;
    logic out_free;
  } ctrl_stat_t;

  function automatic heading_t turn_left(heading_t d);
    return heading_t'(2'(d + 2'd3));
  endfunction

  function automatic heading_t turn_right(heading_t d);
    return heading_t'(2'(d + 2'd1));
  endfunction

  // offsets of the pixel ahead-left of a corner for a given heading
  function automatic logic fl_dx(heading_t d);
    return (d == HEAD_EAST) || (d == HEAD_SOUTH);
  endfunction

  function automatic logic fl_dy(heading_t d);
    return (d == HEAD_SOUTH) || (d == HEAD_WEST);
  endfunction

endpackage

// ===== hw/rtl/bct_ctrl.sv =====
module bct_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  operation,
  input  logic                  cfg_we,
  input  bct_pkg::ctrl_stat_t   stat,
  output logic                  in_ready,
  output bct_pkg::ctrl_cmd_t    cmd
);

  bct_pkg::state_t state, state_next;
  bct_pkg::phase_t phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bct_pkg::ST_CLEAR;
      phase <= bct_pkg::PH_LOADING;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    case (state)
      bct_pkg::ST_CLEAR: begin
        if (stat.clear_last) state_next = bct_pkg::ST_IDLE;
      end
      bct_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (operation == bct_pkg::OP_LOAD) begin
            phase_next = bct_pkg::PH_LOADING;
          end else begin
            case (phase)
              bct_pkg::PH_LOADING: begin
                phase_next = bct_pkg::PH_SCANNING;
                state_next = stat.build_empty ? bct_pkg::ST_SCAN_RD : bct_pkg::ST_BUILD;
              end
              bct_pkg::PH_SCANNING: state_next = bct_pkg::ST_SCAN_RD;
              bct_pkg::PH_WALKING:  state_next = bct_pkg::ST_WALK_UPD;
              default:              state_next = bct_pkg::ST_EMIT_DONE;
            endcase
          end
        end
      end
      bct_pkg::ST_BUILD: begin
        if (stat.build_last) state_next = bct_pkg::ST_FLUSH;
      end
      bct_pkg::ST_FLUSH: state_next = bct_pkg::ST_SCAN_RD;
      bct_pkg::ST_SCAN_RD: begin
        if (!stat.row_ok) begin
          phase_next = bct_pkg::PH_DONE;
          state_next = bct_pkg::ST_EMIT_DONE;
        end else if (stat.col_ok) begin
          state_next = bct_pkg::ST_SCAN_CHK;
        end
      end
      bct_pkg::ST_SCAN_CHK: begin
        if (stat.mask_bit) begin
          if (stat.out_free) begin
            phase_next = bct_pkg::PH_WALKING;
            state_next = bct_pkg::ST_IDLE;
          end
        end else begin
          state_next = bct_pkg::ST_SCAN_RD;
        end
      end
      bct_pkg::ST_WALK_UPD: begin
        if (stat.out_free) begin
          state_next = bct_pkg::ST_IDLE;
          if (stat.walk_close) phase_next = bct_pkg::PH_SCANNING;
        end
      end
      bct_pkg::ST_EMIT_DONE: begin
        if (stat.out_free) state_next = bct_pkg::ST_IDLE;
      end
      default: state_next = bct_pkg::ST_IDLE;
    endcase
    if (cfg_we) phase_next = bct_pkg::PH_LOADING;
  end

  always_comb begin
    cmd      = '0;
    in_ready = (state == bct_pkg::ST_IDLE);
    case (state)
      bct_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
      bct_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (operation == bct_pkg::OP_LOAD) begin
            cmd.load_px = 1'b1;
          end else if (phase == bct_pkg::PH_LOADING) begin
            cmd.scan_init = 1'b1;
          end else if (phase == bct_pkg::PH_WALKING) begin
            cmd.walk_rd = 1'b1;
          end
        end
      end
      bct_pkg::ST_BUILD: cmd.build_step = 1'b1;
      bct_pkg::ST_FLUSH: cmd.scan_init = 1'b1;
      bct_pkg::ST_SCAN_RD: begin
        if (stat.row_ok) begin
          if (stat.col_ok) cmd.scan_rd = 1'b1;
          else cmd.scan_wrap = 1'b1;
        end
      end
      bct_pkg::ST_SCAN_CHK: begin
        if (stat.mask_bit) cmd.start = stat.out_free;
        else cmd.scan_next = 1'b1;
      end
      bct_pkg::ST_WALK_UPD:  cmd.walk_upd = stat.out_free;
      bct_pkg::ST_EMIT_DONE: cmd.emit_done = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hw/rtl/bct_datapath.sv =====
module bct_datapath #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [bct_pkg::COORD_W-1:0]  cfg_data,
  input  bct_pkg::ctrl_cmd_t           cmd,
  output bct_pkg::ctrl_stat_t          stat,
  input  logic [bct_pkg::COORD_W-1:0]  pixel_col,
  input  logic [bct_pkg::COORD_W-1:0]  pixel_row,
  input  logic                         pixel_black,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [bct_pkg::COORD_W-1:0]  point_x,
  output logic [bct_pkg::COORD_W-1:0]  point_y,
  output logic                         contour_first,
  output logic                         contour_last,
  output logic                         all_done
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int AW    = CW + RW;
  localparam int DEPTH = 1 << AW;
  localparam int CORD_MAX = (1 << bct_pkg::COORD_W) - 1;
  localparam logic [bct_pkg::COORD_W-1:0] W_CAP =
    bct_pkg::COORD_W'(MAX_WIDTH > CORD_MAX ? CORD_MAX : MAX_WIDTH);
  localparam logic [bct_pkg::COORD_W-1:0] H_CAP =
    bct_pkg::COORD_W'(MAX_HEIGHT > CORD_MAX ? CORD_MAX : MAX_HEIGHT);

  typedef logic [bct_pkg::COORD_W-1:0] coord_t;
  typedef logic [bct_pkg::SCAN_W-1:0]  scan_t;

  function automatic logic in_img(scan_t c, scan_t r, coord_t wd, coord_t ht);
    return (c != '0) && (r != '0) && (c <= {1'b0, wd}) && (r <= {1'b0, ht});
  endfunction

  function automatic logic [AW-1:0] mem_addr(scan_t c, scan_t r);
    scan_t cm;
    scan_t rm;
    cm = c - scan_t'(1);
    rm = r - scan_t'(1);
    return {RW'(rm), CW'(cm)};
  endfunction

  logic pix_mem  [DEPTH];
  logic mask_mem [DEPTH];

  coord_t image_width, image_height, eff_w, eff_h;
  logic [AW-1:0] clr_addr;
  scan_t sc, sr;
  logic bw_en, bw_top_ok;
  logic [AW-1:0] bw_addr;
  logic pa_q, pb_q, in_l_q, in_r_q, mask_q;
  coord_t wx, wy, ox, oy;
  bct_pkg::heading_t heading;

  scan_t lc, lr, rc, rr;
  logic [AW-1:0] pa_addr, pb_addr, pix_waddr, mask_waddr;
  logic pix_we, pix_wdata, mask_we, mask_wdata, out_load, out_free;
  logic bl, br, clr_hit;
  bct_pkg::heading_t h_new;
  coord_t nx, ny;

  assign eff_w = (image_width > W_CAP) ? W_CAP : image_width;
  assign eff_h = (image_height > H_CAP) ? H_CAP : image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= coord_t'(256);
      image_height <= coord_t'(256);
    end else if (cfg_we) begin
      if (cfg_index == bct_pkg::REG_IMAGE_WIDTH) image_width <= cfg_data;
      else image_height <= cfg_data;
    end
  end

  // walker read addresses: pixel ahead-left and ahead-right
  always_comb begin
    bct_pkg::heading_t hr;
    hr = bct_pkg::turn_right(heading);
    lc = {1'b0, wx} + scan_t'(bct_pkg::fl_dx(heading));
    lr = {1'b0, wy} + scan_t'(bct_pkg::fl_dy(heading));
    rc = {1'b0, wx} + scan_t'(bct_pkg::fl_dx(hr));
    rr = {1'b0, wy} + scan_t'(bct_pkg::fl_dy(hr));
  end

  assign pa_addr = cmd.walk_rd ? mem_addr(lc, lr) : mem_addr(sc, sr);
  assign pb_addr = cmd.walk_rd ? mem_addr(rc, rr) : mem_addr(sc, sr - scan_t'(1));

  assign pix_we    = cmd.clear_step |
                     (cmd.load_px & in_img({1'b0, pixel_col}, {1'b0, pixel_row}, eff_w, eff_h));
  assign pix_waddr = cmd.clear_step ? clr_addr :
                     mem_addr({1'b0, pixel_col}, {1'b0, pixel_row});
  assign pix_wdata = cmd.clear_step ? 1'b0 : pixel_black;

  always_ff @(posedge clk) begin
    if (pix_we) pix_mem[pix_waddr] <= pix_wdata;
    if (cmd.walk_rd | cmd.build_step) begin
      pa_q <= pix_mem[pa_addr];
      pb_q <= pix_mem[pb_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_rd) begin
      in_l_q <= in_img(lc, lr, eff_w, eff_h);
      in_r_q <= in_img(rc, rr, eff_w, eff_h);
    end
  end

  // walk step
  always_comb begin
    bl = in_l_q & pa_q;
    br = in_r_q & pb_q;
    if (bl) h_new = bct_pkg::turn_left(heading);
    else if (!br) h_new = bct_pkg::turn_right(heading);
    else h_new = heading;
    nx = wx;
    ny = wy;
    case (h_new)
      bct_pkg::HEAD_NORTH: ny = (wy != '0) ? wy - coord_t'(1) : wy;
      bct_pkg::HEAD_SOUTH: ny = wy + coord_t'(1);
      bct_pkg::HEAD_EAST:  nx = wx + coord_t'(1);
      default:             nx = (wx != '0) ? wx - coord_t'(1) : wx;
    endcase
    clr_hit = (h_new == bct_pkg::HEAD_EAST) &&
              in_img({1'b0, nx}, {1'b0, ny} + scan_t'(1), eff_w, eff_h);
  end

  assign mask_we    = bw_en | (cmd.walk_upd & clr_hit);
  assign mask_waddr = bw_en ? bw_addr : mem_addr({1'b0, nx}, {1'b0, ny} + scan_t'(1));
  assign mask_wdata = bw_en ? (pa_q & ~(pb_q & bw_top_ok)) : 1'b0;

  always_ff @(posedge clk) begin
    if (mask_we) mask_mem[mask_waddr] <= mask_wdata;
    if (cmd.scan_rd) mask_q <= mask_mem[mem_addr(sc, sr)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      bw_en    <= 1'b0;
      sc       <= scan_t'(1);
      sr       <= scan_t'(1);
    end else begin
      if (cmd.clear_step) clr_addr <= clr_addr + AW'(1);
      bw_en <= cmd.build_step;
      if (cmd.scan_init) begin
        sc <= scan_t'(1);
        sr <= scan_t'(1);
      end else if (cmd.build_step) begin
        if (sc == {1'b0, eff_w}) begin
          sc <= scan_t'(1);
          sr <= sr + scan_t'(1);
        end else begin
          sc <= sc + scan_t'(1);
        end
      end else if (cmd.scan_wrap) begin
        sc <= scan_t'(1);
        sr <= sr + scan_t'(1);
      end else if (cmd.scan_next | cmd.start) begin
        sc <= sc + scan_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.build_step) begin
      bw_addr   <= mem_addr(sc, sr);
      bw_top_ok <= (sr != scan_t'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wx      <= '0;
      wy      <= '0;
      ox      <= '0;
      oy      <= '0;
      heading <= bct_pkg::HEAD_EAST;
    end else if (cmd.start) begin
      wx      <= coord_t'(sc - scan_t'(1));
      wy      <= coord_t'(sr - scan_t'(1));
      ox      <= coord_t'(sc - scan_t'(1));
      oy      <= coord_t'(sr - scan_t'(1));
      heading <= bct_pkg::HEAD_EAST;
    end else if (cmd.walk_upd) begin
      wx      <= nx;
      wy      <= ny;
      heading <= h_new;
    end
  end

  assign out_free = !out_valid || out_ready;
  assign out_load = cmd.start | cmd.walk_upd | cmd.emit_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      point_x       <= coord_t'(sc - scan_t'(1));
      point_y       <= coord_t'(sr - scan_t'(1));
      contour_first <= 1'b1;
      contour_last  <= 1'b0;
      all_done      <= 1'b0;
    end else if (cmd.walk_upd) begin
      point_x       <= nx;
      point_y       <= ny;
      contour_first <= 1'b0;
      contour_last  <= (nx == ox) && (ny == oy);
      all_done      <= 1'b0;
    end else if (cmd.emit_done) begin
      point_x       <= '0;
      point_y       <= '0;
      contour_first <= 1'b0;
      contour_last  <= 1'b0;
      all_done      <= 1'b1;
    end
  end

  always_comb begin
    stat.clear_last  = &clr_addr;
    stat.build_empty = (eff_w == '0) || (eff_h == '0);
    stat.build_last  = (sc == {1'b0, eff_w}) && (sr == {1'b0, eff_h});
    stat.row_ok      = (sr != '0) && (sr <= {1'b0, eff_h});
    stat.col_ok      = (sc != '0) && (sc <= {1'b0, eff_w});
    stat.mask_bit    = mask_q;
    stat.walk_close  = (nx == ox) && (ny == oy);
    stat.out_free    = out_free;
  end

endmodule

// ===== hw/rtl/binary_contour_tracer_core.sv =====
// Binary contour tracer. Load items (operation 0) write one pixel of the image; each fetch
// item (operation 1) returns one corner point, or a done result once no contour is left.
// While a contour is being walked a fetch reads the two-port pixel memory and then does
// the heading/step update, which waits until the result register is free. The first fetch
// after any load or register write rebuilds the start mask, one pixel per cycle. Searching
// for the next start reads and tests one mask bit at a time and wraps at each row end.
// After reset the pixel memory is cleared, one entry per cycle, and no item is accepted
// until it finishes; register writes must be made only while no item is in flight, which
// the block itself does not enforce.
module binary_contour_tracer_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         operation,
  input  logic [bct_pkg::COORD_W-1:0]  pixel_col,
  input  logic [bct_pkg::COORD_W-1:0]  pixel_row,
  input  logic                         pixel_black,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bct_pkg::COORD_W-1:0]  point_x,
  output logic [bct_pkg::COORD_W-1:0]  point_y,
  output logic                         contour_first,
  output logic                         contour_last,
  output logic                         all_done,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [bct_pkg::COORD_W-1:0]  cfg_data
);

  bct_pkg::ctrl_cmd_t  cmd;
  bct_pkg::ctrl_stat_t stat;

  bct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .cfg_we    (cfg_we),
    .stat      (stat),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  bct_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .stat          (stat),
    .pixel_col     (pixel_col),
    .pixel_row     (pixel_row),
    .pixel_black   (pixel_black),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .point_x       (point_x),
    .point_y       (point_y),
    .contour_first (contour_first),
    .contour_last  (contour_last),
    .all_done      (all_done)
  );

`ifndef SYNTH
  // a new result must never overwrite one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.start || cmd.walk_upd || cmd.emit_done) |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && all_done) |-> (point_x == '0 && point_y == '0 &&
                                 !contour_first && !contour_last))
    else $error("done result carries point data");

  // a contour needs at least one step between its first and last points
  a_first_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(contour_first && contour_last))
    else $error("point both opens and closes a contour");

  a_idle_only: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !(cmd.build_step || cmd.scan_rd || cmd.walk_upd || cmd.clear_step))
    else $error("input taken while busy");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int MAXW = 256;
  localparam int MAXH = 256;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEM_TARGET = 1500;
  localparam int NSPEC = 9;
  // odd sizes: full size first, then thin strips, oversized, empty and tiny images
  localparam int SPEC_W [NSPEC] = '{256, 256, 1, 511, 3, 0, 5, 1, 2};
  localparam int SPEC_H [NSPEC] = '{256, 1, 256, 3, 511, 5, 0, 1, 2};

  typedef struct packed {
    logic [bct_pkg::COORD_W-1:0] x;
    logic [bct_pkg::COORD_W-1:0] y;
    logic                        first;
    logic                        last;
    logic                        done;
  } corner_t;

  typedef struct packed {
    logic                        op;
    logic [bct_pkg::COORD_W-1:0] col;
    logic [bct_pkg::COORD_W-1:0] row;
    logic                        black;
    logic                        typed;
    corner_t                     pt;
  } dir_row_t;

  // run with a 4x3 image; typed rows carry the point expected
  localparam dir_row_t DIRECTED [25] = '{
    '{bct_pkg::OP_FETCH, 0, 0, 0, 1, '{0, 0, 0, 0, 1}},
    '{bct_pkg::OP_FETCH, 0, 0, 0, 1, '{0, 0, 0, 0, 1}},
    '{bct_pkg::OP_LOAD, 1, 1, 1, 0, '0},
    '{bct_pkg::OP_LOAD, 0, 1, 1, 0, '0},
    '{bct_pkg::OP_LOAD, 1, 0, 1, 0, '0},
    '{bct_pkg::OP_LOAD, 5, 2, 1, 0, '0},
    '{bct_pkg::OP_LOAD, 2, 4, 1, 0, '0},
    '{bct_pkg::OP_LOAD, 511, 511, 1, 0, '0},
    '{bct_pkg::OP_LOAD, 256, 256, 1, 0, '0},
    '{bct_pkg::OP_LOAD, 4, 3, 1, 0, '0},
    '{bct_pkg::OP_FETCH, 0, 0, 0, 1, '{0, 0, 1, 0, 0}},
    '{bct_pkg::OP_FETCH, 0, 0, 0, 0, '0},
    '{bct_pkg::OP_FETCH, 0, 0, 0, 0, '0},
    '{bct_pkg::OP_FETCH, 0, 0, 0, 0, '0},
    '{bct_pkg::OP_FETCH, 0, 0, 0, 1, '{0, 0, 0, 1, 0}},
    '{bct_pkg::OP_FETCH, 511, 511, 1, 1, '{3, 2, 1, 0, 0}},
    '{bct_pkg::OP_FETCH, 0, 0, 0, 0, '0},
    '{bct_pkg::OP_FETCH, 0, 0, 0, 0, '0},
    '{bct_pkg::OP_LOAD, 1, 1, 0, 0, '0},
    '{bct_pkg::OP_FETCH, 0, 0, 0, 1, '{3, 2, 1, 0, 0}},
    '{bct_pkg::OP_FETCH, 0, 0, 0, 0, '0},
    '{bct_pkg::OP_FETCH, 0, 0, 0, 0, '0},
    '{bct_pkg::OP_FETCH, 0, 0, 0, 0, '0},
    '{bct_pkg::OP_FETCH, 0, 0, 0, 1, '{3, 2, 0, 1, 0}},
    '{bct_pkg::OP_FETCH, 0, 0, 0, 1, '{0, 0, 0, 0, 1}}
  };

  logic                        clk;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        operation = bct_pkg::OP_LOAD;
  logic [bct_pkg::COORD_W-1:0] pixel_col = '0;
  logic [bct_pkg::COORD_W-1:0] pixel_row = '0;
  logic                        pixel_black = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [bct_pkg::COORD_W-1:0] point_x;
  logic [bct_pkg::COORD_W-1:0] point_y;
  logic                        contour_first;
  logic                        contour_last;
  logic                        all_done;
  logic                        cfg_we = 1'b0;
  logic                        cfg_index = bct_pkg::REG_IMAGE_WIDTH;
  logic [bct_pkg::COORD_W-1:0] cfg_data = '0;

  binary_contour_tracer_core dut (.*);

  // tracer state mirrored in the testbench
  bit                          img_bits [MAXW*MAXH];
  bit                          start_bits [MAXW*MAXH];
  logic [bct_pkg::COORD_W-1:0] width_reg, height_reg;
  logic [bct_pkg::COORD_W-1:0] walk_x, walk_y, home_x, home_y;
  bct_pkg::heading_t           walk_dir;
  int                          scan_c, scan_r;
  bct_pkg::phase_t             trace_phase;
  bit                          tracer_done;

  corner_t pending_corners [$];
  corner_t typed_pt;
  bit      typed_on = 1'b0;
  bit      quiet = 1'b0;
  bit      gappy = 1'b0;
  int      n_accepted = 0;
  int      n_items = 0;
  int      n_errors = 0;
  int      n_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_width();
    return (width_reg > MAXW) ? MAXW : int'(width_reg);
  endfunction

  function automatic int eff_height();
    return (height_reg > MAXH) ? MAXH : int'(height_reg);
  endfunction

  function automatic bit in_image(int c, int r);
    return c >= 1 && r >= 1 && c <= eff_width() && r <= eff_height();
  endfunction

  function automatic int px_index(int c, int r);
    return (r - 1) * MAXW + (c - 1);
  endfunction

  function automatic bit is_black(int c, int r);
    if (!in_image(c, r)) return 1'b0;
    return img_bits[px_index(c, r)];
  endfunction

  function automatic bct_pkg::heading_t rot_cw(bct_pkg::heading_t d);
    logic [1:0] v;
    v = d + 2'd1;
    return bct_pkg::heading_t'(v);
  endfunction

  function automatic bct_pkg::heading_t rot_ccw(bct_pkg::heading_t d);
    logic [1:0] v;
    v = d - 2'd1;
    return bct_pkg::heading_t'(v);
  endfunction

  function automatic void tracer_reset();
    width_reg = bct_pkg::COORD_W'(MAXW);
    height_reg = bct_pkg::COORD_W'(MAXH);
    img_bits = '{default: 1'b0};
    start_bits = '{default: 1'b0};
    walk_x = '0;
    walk_y = '0;
    home_x = '0;
    home_y = '0;
    walk_dir = bct_pkg::HEAD_EAST;
    scan_c = 1;
    scan_r = 1;
    trace_phase = bct_pkg::PH_LOADING;
    tracer_done = 1'b0;
  endfunction

  function automatic void build_starts();
    start_bits = '{default: 1'b0};
    for (int r = 1; r <= eff_height(); r++)
      for (int c = 1; c <= eff_width(); c++)
        start_bits[px_index(c, r)] = is_black(c, r) && !is_black(c, r - 1);
  endfunction

  // raster search from the scan position; leaves scan past the hit
  function automatic bit find_start();
    while (scan_r >= 1 && scan_r <= eff_height()) begin
      if (scan_c >= 1 && scan_c <= eff_width()) begin
        if (start_bits[px_index(scan_c, scan_r)]) begin
          home_x = bct_pkg::COORD_W'(scan_c - 1);
          home_y = bct_pkg::COORD_W'(scan_r - 1);
          scan_c++;
          return 1'b1;
        end
        scan_c++;
      end else begin
        scan_c = 1;
        scan_r++;
      end
    end
    return 1'b0;
  endfunction

  // pixel ahead-left of the walker's corner when facing d
  function automatic void ahead_left(bct_pkg::heading_t d, output int c, output int r);
    c = int'(walk_x) + ((d == bct_pkg::HEAD_EAST || d == bct_pkg::HEAD_SOUTH) ? 1 : 0);
    r = int'(walk_y) + ((d == bct_pkg::HEAD_SOUTH || d == bct_pkg::HEAD_WEST) ? 1 : 0);
  endfunction

  function automatic void walk_one();
    int lc, lr, rc, rr;
    ahead_left(walk_dir, lc, lr);
    ahead_left(rot_cw(walk_dir), rc, rr);
    if (is_black(lc, lr))
      walk_dir = rot_ccw(walk_dir);
    else if (!is_black(rc, rr))
      walk_dir = rot_cw(walk_dir);
    case (walk_dir)
      bct_pkg::HEAD_NORTH: if (walk_y > 0) walk_y = walk_y - 1'b1;
      bct_pkg::HEAD_SOUTH: walk_y = walk_y + 1'b1;
      bct_pkg::HEAD_EAST:  walk_x = walk_x + 1'b1;
      default:             if (walk_x > 0) walk_x = walk_x - 1'b1;
    endcase
    // eastward step retires the start bit below-left of the new corner
    if (walk_dir == bct_pkg::HEAD_EAST && in_image(int'(walk_x), int'(walk_y) + 1))
      start_bits[px_index(int'(walk_x), int'(walk_y) + 1)] = 1'b0;
  endfunction

  function automatic bit trace_item(logic op, logic [bct_pkg::COORD_W-1:0] col,
                                    logic [bct_pkg::COORD_W-1:0] row, logic blk,
                                    output corner_t pt);
    pt = '0;
    if (op == bct_pkg::OP_LOAD) begin
      if (in_image(int'(col), int'(row))) img_bits[px_index(int'(col), int'(row))] = blk;
      trace_phase = bct_pkg::PH_LOADING;
      tracer_done = 1'b0;
      return 1'b0;
    end
    if (trace_phase == bct_pkg::PH_LOADING) begin
      build_starts();
      scan_c = 1;
      scan_r = 1;
      trace_phase = bct_pkg::PH_SCANNING;
    end
    if (trace_phase == bct_pkg::PH_SCANNING) begin
      if (find_start()) begin
        walk_x = home_x;
        walk_y = home_y;
        walk_dir = bct_pkg::HEAD_EAST;
        pt.first = 1'b1;
        trace_phase = bct_pkg::PH_WALKING;
      end else begin
        trace_phase = bct_pkg::PH_DONE;
      end
    end else if (trace_phase == bct_pkg::PH_WALKING) begin
      walk_one();
      if (walk_x == home_x && walk_y == home_y) begin
        pt.last = 1'b1;
        trace_phase = bct_pkg::PH_SCANNING;
      end
    end
    if (trace_phase == bct_pkg::PH_DONE) begin
      pt = '0;
      pt.done = 1'b1;
      tracer_done = 1'b1;
      return 1'b1;
    end
    pt.x = walk_x;
    pt.y = walk_y;
    return 1'b1;
  endfunction

  function automatic void flag_point(bit had_want, corner_t want, corner_t got);
    n_errors++;
    if (n_errors <= 10) begin
      if (had_want)
        $display({"point mismatch: expected x=%0d y=%0d first=%0b last=%0b done=%0b,",
                  " got x=%0d y=%0d first=%0b last=%0b done=%0b"},
                 want.x, want.y, want.first, want.last, want.done,
                 got.x, got.y, got.first, got.last, got.done);
      else
        $display("unexpected point: x=%0d y=%0d first=%0b last=%0b done=%0b",
                 got.x, got.y, got.first, got.last, got.done);
    end
  endfunction

  always @(posedge clk) begin
    corner_t pt, got, want;
    if (rst) begin
      tracer_reset();
    end else begin
      if (cfg_we) begin
        if (cfg_index == bct_pkg::REG_IMAGE_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
        trace_phase = bct_pkg::PH_LOADING;
        tracer_done = 1'b0;
      end
      if (in_valid && in_ready) begin
        n_accepted++;
        if (trace_item(operation, pixel_col, pixel_row, pixel_black, pt))
          pending_corners.push_back(typed_on ? typed_pt : pt);
      end
      if (out_valid && out_ready) begin
        got = {point_x, point_y, contour_first, contour_last, all_done};
        if (pending_corners.size() == 0) begin
          flag_point(1'b0, '0, got);
        end else begin
          want = pending_corners.pop_front();
          if (got !== want) flag_point(1'b1, want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side stalls
  initial begin
    forever begin
      if (quiet || $urandom_range(0, 2) != 0) begin
        out_ready = 1'b1;
        if (quiet) @(negedge clk);
        else if ($urandom_range(0, 9) == 0) repeat ($urandom_range(50, 200)) @(negedge clk);
        else repeat ($urandom_range(1, 12)) @(negedge clk);
      end else begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
    end
  end

  task automatic send_item(logic op, int col, int row, logic blk);
    int target;
    target = n_accepted + 1;
    if (!quiet && gappy && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    operation = op;
    pixel_col = col[bct_pkg::COORD_W-1:0];
    pixel_row = row[bct_pkg::COORD_W-1:0];
    pixel_black = blk;
    in_valid = 1'b1;
    do @(negedge clk); while (n_accepted < target);
    typed_on = 1'b0;
    if (op == bct_pkg::OP_FETCH || in_image(col, row)) n_items++;
  endtask

  // hold off until every point is back, then let a trailing load finish
  task automatic settle();
    in_valid = 1'b0;
    while (pending_corners.size() != 0) @(negedge clk);
    if (!quiet) repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    cfg_index = idx;
    cfg_data = val[bct_pkg::COORD_W-1:0];
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_size(int w, int h);
    settle();
    write_reg(bct_pkg::REG_IMAGE_WIDTH, w);
    write_reg(bct_pkg::REG_IMAGE_HEIGHT, h);
  endtask

  task automatic fetch_any();
    send_item(bct_pkg::OP_FETCH, $urandom_range(0, 511), $urandom_range(0, 511),
              $urandom_range(0, 1));
  endtask

  task automatic run_image(int w, int h);
    int ew, eh, density, n_fetch;
    set_size(w, h);
    gappy = $urandom_range(0, 3) != 0;
    ew = (w > MAXW) ? MAXW : w;
    eh = (h > MAXH) ? MAXH : h;
    repeat ($urandom_range(1, 3))
      send_item(bct_pkg::OP_LOAD, $urandom_range(0, 511), $urandom_range(0, 511), 1'b1);
    if (ew * eh <= 144) begin
      density = $urandom_range(1, 3) * 25;
      for (int r = 1; r <= eh; r++)
        for (int c = 1; c <= ew; c++) begin
          send_item(bct_pkg::OP_LOAD, c, r, $urandom_range(0, 99) < density);
          if ($urandom_range(0, 19) == 0)
            send_item(bct_pkg::OP_LOAD, $urandom_range(0, 511), $urandom_range(0, 511),
                      1'b1);
        end
    end else begin
      send_item(bct_pkg::OP_LOAD, 1, 1, 1'b1);
      send_item(bct_pkg::OP_LOAD, ew, 1, 1'b1);
      send_item(bct_pkg::OP_LOAD, 1, eh, 1'b1);
      send_item(bct_pkg::OP_LOAD, ew, eh, 1'b1);
      repeat (40)
        send_item(bct_pkg::OP_LOAD, $urandom_range(1, ew), $urandom_range(1, eh),
                  $urandom_range(0, 9) < 7);
    end
    n_fetch = 0;
    do begin
      // a load mid-trace forces a rebuild; kept off big images where that is slow
      if (ew * eh <= 1024 && $urandom_range(0, 39) == 0)
        send_item(bct_pkg::OP_LOAD, $urandom_range(1, ew), $urandom_range(1, eh),
                  $urandom_range(0, 1));
      else if (!quiet && $urandom_range(0, 59) == 0)
        settle();
      fetch_any();
      n_fetch++;
    end while (!tracer_done && n_fetch < 300);
    repeat ($urandom_range(0, 2)) fetch_any();
  endtask

  initial begin
    int spec_i, phase_no;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    set_size(4, 3);
    gappy = 1'b1;
    foreach (DIRECTED[i]) begin
      typed_on = DIRECTED[i].typed;
      typed_pt = DIRECTED[i].pt;
      send_item(DIRECTED[i].op, int'(DIRECTED[i].col), int'(DIRECTED[i].row),
                DIRECTED[i].black);
    end

    spec_i = 0;
    phase_no = 0;
    while (n_items < ITEM_TARGET || spec_i < NSPEC) begin
      if (n_items >= ITEM_TARGET - 200) quiet = 1'b1;
      if (spec_i < NSPEC && (phase_no % 3 == 1 || n_items >= ITEM_TARGET)) begin
        run_image(SPEC_W[spec_i], SPEC_H[spec_i]);
        spec_i++;
      end else begin
        run_image($urandom_range(1, 12), $urandom_range(1, 12));
      end
      phase_no++;
    end

    in_valid = 1'b0;
    while (pending_corners.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (n_errors == 0 && pending_corners.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== binary_contour_tracer_core.f =====
hw/rtl/bct_pkg.sv
hw/rtl/bct_ctrl.sv
hw/rtl/bct_datapath.sv
hw/rtl/binary_contour_tracer_core.sv
tb/sv/testbench.sv
